/* rtl/fcc_pkg.sv */
// ----------------------------------------------------------------------------
// fcc_pkg
// Shared types, constants and helpers of the droplet spacing checker.
// ----------------------------------------------------------------------------
package fcc_pkg;

    localparam int NET_SLOTS_DEF  = 64;
    localparam int TIME_STEPS_DEF = 128;
    localparam int GRID_SIDE_DEF  = 64;

    localparam int FUNC_W  = 2;
    localparam int NET_FW  = 6;
    localparam int SLOT_FW = 6;
    localparam int TIME_FW = 7;
    localparam int POS_FW  = 6;
    localparam int RANK_FW = 6;
    localparam int CNT_FW  = 7;

    localparam int MIN_SPACING = 2;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_PATH  = 2'd0,
        FUNC_ORDER = 2'd1,
        FUNC_CHECK = 2'd2
    } fcc_func_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_ORD_CHK,
        ST_PATH_CUR,
        ST_PATH_PREV,
        ST_DONE
    } fcc_state_t;

    typedef struct packed {
        logic [FUNC_W-1:0]  func;
        logic [NET_FW-1:0]  net;
        logic [SLOT_FW-1:0] slot;
        logic [TIME_FW-1:0] time_step;
        logic [POS_FW-1:0]  pos_x;
        logic [POS_FW-1:0]  pos_y;
    } fcc_in_t;

    typedef struct packed {
        logic               conflict;
        logic [RANK_FW-1:0] conflict_rank;
    } fcc_out_t;

    typedef struct packed {
        logic latch;     // capture check word, clear rank and hit
        logic path_wr;
        logic ord_wr;
        logic ord_rd;
        logic ord_next;  // order read at rank + 1
        logic path_rd;
        logic path_prev; // path read at t - 1
        logic inc_rank;
        logic set_hit;
        logic load_out;
    } fcc_cmd_t;

    typedef struct packed {
        logic t_bad;
        logic t_zero;
        logic limit_zero;
        logic rank_last;
        logic ord_match;
        logic ord_skip;
        logic hit;
    } fcc_sts_t;

    function automatic logic fcc_too_close(
        input logic [POS_FW-1:0] ax,
        input logic [POS_FW-1:0] ay,
        input logic [POS_FW-1:0] bx,
        input logic [POS_FW-1:0] by
    );
        logic [POS_FW-1:0] ddx;
        logic [POS_FW-1:0] ddy;
        ddx = (ax > bx) ? ax - bx : bx - ax;
        ddy = (ay > by) ? ay - by : by - ay;
        return (ddx < POS_FW'(MIN_SPACING)) && (ddy < POS_FW'(MIN_SPACING));
    endfunction

endpackage

/* rtl/fcc_word_if.sv */
// ----------------------------------------------------------------------------
// fcc_word_if
// Valid/ready channel carrying one word per handshake.
// ----------------------------------------------------------------------------
interface fcc_word_if #(
    parameter type word_t = logic
);
    logic  valid;
    logic  ready;
    word_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

/* rtl/fcc_ram.sv */
// ----------------------------------------------------------------------------
// fcc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module fcc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

/* rtl/fcc_ctrl.sv */
// ----------------------------------------------------------------------------
// fcc_ctrl
// Sequencer for table writes and the rank walk of a check.
// ----------------------------------------------------------------------------
module fcc_ctrl
    import fcc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic [FUNC_W-1:0] in_func,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    input  fcc_sts_t          sts,
    output fcc_cmd_t          cmd
);
    fcc_state_t state_reg;
    fcc_state_t state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       accept;

    assign in_ready  = (state_reg == ST_IDLE);
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && (in_func == FUNC_CHECK))
                begin
                    state_next = ST_START;
                end
            end
            ST_START:
            begin
                if (sts.t_bad || sts.limit_zero)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_ORD_CHK;
                end
            end
            ST_ORD_CHK:
            begin
                priority if (sts.ord_match)
                begin
                    state_next = ST_DONE;
                end
                else if (sts.ord_skip)
                begin
                    state_next = sts.rank_last ? ST_DONE : ST_ORD_CHK;
                end
                else
                begin
                    state_next = ST_PATH_CUR;
                end
            end
            ST_PATH_CUR:
            begin
                priority if (sts.hit)
                begin
                    state_next = ST_DONE;
                end
                else if (sts.t_zero)
                begin
                    state_next = sts.rank_last ? ST_DONE : ST_ORD_CHK;
                end
                else
                begin
                    state_next = ST_PATH_PREV;
                end
            end
            ST_PATH_PREV:
            begin
                if (sts.hit || sts.rank_last)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_ORD_CHK;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        cmd = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.latch   = accept && (in_func == FUNC_CHECK);
                cmd.path_wr = accept && (in_func == FUNC_PATH);
                cmd.ord_wr  = accept && (in_func == FUNC_ORDER);
            end
            ST_START:
            begin
                cmd.ord_rd = !(sts.t_bad || sts.limit_zero);
            end
            ST_ORD_CHK:
            begin
                priority if (sts.ord_match)
                begin
                    cmd = '0;
                end
                else if (sts.ord_skip)
                begin
                    cmd.ord_rd   = !sts.rank_last;
                    cmd.ord_next = !sts.rank_last;
                    cmd.inc_rank = !sts.rank_last;
                end
                else
                begin
                    cmd.path_rd = 1'b1;
                end
            end
            ST_PATH_CUR:
            begin
                priority if (sts.hit)
                begin
                    cmd.set_hit = 1'b1;
                end
                else if (sts.t_zero)
                begin
                    cmd.ord_rd   = !sts.rank_last;
                    cmd.ord_next = !sts.rank_last;
                    cmd.inc_rank = !sts.rank_last;
                end
                else
                begin
                    // prefetch the next rank while the t - 1 point is read
                    cmd.path_rd   = 1'b1;
                    cmd.path_prev = 1'b1;
                    cmd.ord_rd    = 1'b1;
                    cmd.ord_next  = 1'b1;
                end
            end
            ST_PATH_PREV:
            begin
                cmd.set_hit  = sts.hit;
                cmd.inc_rank = !sts.hit && !sts.rank_last;
            end
            ST_DONE:
            begin
                cmd.load_out = !out_valid_reg || out_ready;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end
endmodule

/* rtl/fcc_datapath.sv */
// ----------------------------------------------------------------------------
// fcc_datapath
// Order and path tables, rank counter, spacing test and result register.
// ----------------------------------------------------------------------------
module fcc_datapath
    import fcc_pkg::*;
#(
    parameter int NET_SLOTS  = NET_SLOTS_DEF,
    parameter int TIME_STEPS = TIME_STEPS_DEF,
    parameter int GRID_SIDE  = GRID_SIDE_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  fcc_in_t           in_word,
    input  logic [CNT_FW-1:0] net_count,
    input  fcc_cmd_t          cmd,
    output fcc_sts_t          sts,
    output fcc_out_t          out_word
);
    localparam int NET_W      = $clog2(NET_SLOTS);
    localparam int TIME_W     = $clog2(TIME_STEPS);
    localparam int RANK_W     = $clog2(NET_SLOTS + 1);
    localparam int PATH_DEPTH = NET_SLOTS * (2 ** TIME_W);
    localparam int PATH_AW    = NET_W + TIME_W;
    localparam int PATH_DW    = 2 * POS_FW;

    logic [NET_FW-1:0] net_reg;
    logic [TIME_W-1:0] t_reg;
    logic [POS_FW-1:0] px_reg;
    logic [POS_FW-1:0] py_reg;
    logic              t_bad_reg;
    logic [RANK_W-1:0] rank_reg;
    logic              hit_reg;
    fcc_out_t          out_word_reg;

    logic [RANK_W-1:0]  limit;
    logic [RANK_W-1:0]  rank_inc;
    logic               ord_we;
    logic [NET_W-1:0]   ord_raddr;
    logic [NET_FW-1:0]  ord_q;
    logic               path_we;
    logic [PATH_AW-1:0] path_waddr;
    logic [TIME_W-1:0]  path_rt;
    logic [PATH_AW-1:0] path_raddr;
    logic [PATH_DW-1:0] path_q;

    // hold the fields of the check in progress
    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            net_reg   <= in_word.net;
            t_reg     <= TIME_W'(in_word.time_step);
            px_reg    <= in_word.pos_x;
            py_reg    <= in_word.pos_y;
            t_bad_reg <= (int'(in_word.time_step) >= TIME_STEPS);
        end
        if (cmd.load_out)
        begin
            out_word_reg.conflict      <= hit_reg;
            out_word_reg.conflict_rank <= hit_reg ? RANK_FW'(rank_reg) : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rank_reg <= '0;
            hit_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.latch)
            begin
                rank_reg <= '0;
                hit_reg  <= 1'b0;
            end
            else
            begin
                if (cmd.inc_rank)
                begin
                    rank_reg <= rank_inc;
                end
                if (cmd.set_hit)
                begin
                    hit_reg <= 1'b1;
                end
            end
        end
    end

    // walk length, clamped to the table size
    assign limit    = (int'(net_count) < NET_SLOTS) ? RANK_W'(net_count)
                                                    : RANK_W'(NET_SLOTS);
    assign rank_inc = rank_reg + RANK_W'(1);

    // order table
    assign ord_we    = cmd.ord_wr && (int'(in_word.slot) < NET_SLOTS);
    assign ord_raddr = cmd.ord_next ? rank_inc[NET_W-1:0] : rank_reg[NET_W-1:0];

    fcc_ram #(
        .WIDTH (NET_FW),
        .DEPTH (NET_SLOTS)
    ) u_ord_ram (
        .clk   (clk),
        .we    (ord_we),
        .waddr (NET_W'(in_word.slot)),
        .wdata (in_word.net),
        .re    (cmd.ord_rd),
        .raddr (ord_raddr),
        .rdata (ord_q)
    );

    // path table, one entry per net and time step
    assign path_we    = cmd.path_wr
                     && (int'(in_word.net) < NET_SLOTS)
                     && (int'(in_word.time_step) < TIME_STEPS)
                     && (int'(in_word.pos_x) < GRID_SIDE)
                     && (int'(in_word.pos_y) < GRID_SIDE);
    assign path_waddr = {NET_W'(in_word.net), TIME_W'(in_word.time_step)};
    assign path_rt    = cmd.path_prev ? (t_reg - TIME_W'(1)) : t_reg;
    assign path_raddr = {NET_W'(ord_q), path_rt};

    fcc_ram #(
        .WIDTH (PATH_DW),
        .DEPTH (PATH_DEPTH)
    ) u_path_ram (
        .clk   (clk),
        .we    (path_we),
        .waddr (path_waddr),
        .wdata ({in_word.pos_x, in_word.pos_y}),
        .re    (cmd.path_rd),
        .raddr (path_raddr),
        .rdata (path_q)
    );

    assign sts.t_bad      = t_bad_reg;
    assign sts.t_zero     = (t_reg == '0);
    assign sts.limit_zero = (limit == '0);
    assign sts.rank_last  = ({1'b0, rank_inc} >= {1'b0, limit});
    assign sts.ord_match  = (ord_q == net_reg);
    assign sts.ord_skip   = (int'(ord_q) >= NET_SLOTS);
    assign sts.hit        = fcc_too_close(px_reg, py_reg,
                                          path_q[PATH_DW-1:POS_FW], path_q[POS_FW-1:0]);

    assign out_word = out_word_reg;
endmodule

/* rtl/fluidic_constraint_check_core.sv */
// ----------------------------------------------------------------------------
// fluidic_constraint_check_core
// Droplet-routing spacing checker with APB register port.
// ----------------------------------------------------------------------------
// Words on req either load the tables or ask for a check. A path write
// (func 0) stores the grid point of a net at a time step; an order write
// (func 1) puts a net id at a routing rank. Neither gives a result word.
// A check (func 2) walks the ranks from 0 up to net_count - 1 (net_count
// clamped to NET_SLOTS), stops at the rank holding the checked net, and
// returns on rsp the first rank whose net sits closer than 2 in both x and
// y at t or, when t > 0, at t - 1, with conflict set; conflict_rank is 0
// when none is found. Each rank walked needs one order-table read and,
// past the first time step, two path reads through the single read port
// of the path memory, the next rank's order read overlapping the second
// path read. The path memory holds NET_SLOTS * 2^ceil(log2(TIME_STEPS))
// entries of 12 bits. Table contents
// are undefined after reset and must be written before a check reads them.
// Words are taken only between checks; a finished result waits in its
// output register while table writes continue to flow. net_count sits at
// byte address 0; the user must write it only while the block is idle, which the block itself does not enforce.
// ----------------------------------------------------------------------------
module fluidic_constraint_check_core
    import fcc_pkg::*;
#(
    parameter int NET_SLOTS  = NET_SLOTS_DEF,
    parameter int TIME_STEPS = TIME_STEPS_DEF,
    parameter int GRID_SIDE  = GRID_SIDE_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    fcc_word_if.sink    req,
    fcc_word_if.source  rsp,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    // register select: bit 2 of the byte address picks the register index
    localparam logic REG_NET_COUNT = 1'b0;

    logic [CNT_FW-1:0] net_count_reg;
    logic              cfg_wr;
    fcc_cmd_t          cmd;
    fcc_sts_t          sts;
    fcc_in_t           in_word;
    fcc_out_t          out_word;

    // APB: no wait states, write lands on the access phase
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_NET_COUNT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            net_count_reg <= '0;
        end
        else if (cfg_wr)
        begin
            net_count_reg <= pwdata[CNT_FW-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_NET_COUNT) ? 32'(net_count_reg) : '0;

    assign in_word = req.payload;

    // sequencer: owns the handshakes and the walk order
    fcc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_func   (in_word.func),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // tables, rank counter, spacing test, result register
    fcc_datapath #(
        .NET_SLOTS  (NET_SLOTS),
        .TIME_STEPS (TIME_STEPS),
        .GRID_SIDE  (GRID_SIDE)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_word   (in_word),
        .net_count (net_count_reg),
        .cmd       (cmd),
        .sts       (sts),
        .out_word  (out_word)
    );

    assign rsp.payload = out_word;
endmodule

/* rtl/fcc_checker.sv */
// ----------------------------------------------------------------------------
// fcc_checker
// Port-level checks of the spacing checker, bound to the top level.
// ----------------------------------------------------------------------------
module fcc_checker
    import fcc_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               req_valid,
    input logic               req_ready,
    input logic [FUNC_W-1:0]  req_func,
    input logic               rsp_valid,
    input logic               rsp_ready,
    input logic               rsp_conflict,
    input logic [RANK_FW-1:0] rsp_rank
);
    // a stalled result word holds
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable({rsp_conflict, rsp_rank}))
    else $error("result word changed while stalled");

    // no conflict means rank 0
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_conflict |-> rsp_rank == '0)
    else $error("nonzero rank without conflict");

    // input side closes only after a check word was taken
    assert property (@(posedge clk) disable iff (!rst_n)
        $fell(req_ready) |-> $past(req_valid && (req_func == FUNC_CHECK)))
    else $error("input stalled without a check word");

    // a new result appears only at the end of a walk
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> !$past(req_ready))
    else $error("result without a check in progress");
endmodule

bind fluidic_constraint_check_core fcc_checker u_fcc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .req_valid    (req.valid),
    .req_ready    (req.ready),
    .req_func     (req.payload.func),
    .rsp_valid    (rsp.valid),
    .rsp_ready    (rsp.ready),
    .rsp_conflict (rsp.payload.conflict),
    .rsp_rank     (rsp.payload.conflict_rank)
);

/* bench/tb.sv */
// ----------------------------------------------------------------------------
// tb - droplet spacing checker testbench
// Drives table loads and spacing checks into fluidic_constraint_check_core,
// predicts every result word from a local copy of the order table, the path
// tables and net_count, and compares each returned word field by field.
// Both channels stall at random. net_count is swept through its extremes
// over the APB port and read back after each write.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import fcc_pkg::*;

    localparam int CLK_PERIOD    = 8;
    localparam int RESET_CYCLES  = 8;
    // Allow for the slowest check plus the longest stall on both sides, and
    // keep a wide margin.
    localparam int IDLE_LIMIT    = 3000;
    // Table writes give no result word, so give them time to land before
    // touching the register.
    localparam int SETTLE_CYCLES = 12;
    localparam int TAIL_CYCLES   = 20;
    localparam int PHASE_ITEMS   = 104;
    localparam int PHASES        = 8;

    localparam logic [2:0]        REG_NET_COUNT = 3'd0;
    // func value the block has no operation for; it must be dropped.
    localparam logic [FUNC_W-1:0] FUNC_NOP      = 2'd3;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    fcc_word_if #(.word_t(fcc_in_t))  req_if ();
    fcc_word_if #(.word_t(fcc_out_t)) rsp_if ();

    fluidic_constraint_check_core uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req_if),
        .rsp     (rsp_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // ------------------------------------------------------------------
    // Local copy of the block's tables. The known flags track which
    // entries have been written, so that no check ever walks into an
    // entry whose contents are still undefined.
    // ------------------------------------------------------------------
    logic [POS_FW-1:0]  path_x     [NET_SLOTS_DEF][TIME_STEPS_DEF];
    logic [POS_FW-1:0]  path_y     [NET_SLOTS_DEF][TIME_STEPS_DEF];
    bit                 path_known [NET_SLOTS_DEF][TIME_STEPS_DEF];
    logic [NET_FW-1:0]  rank_net   [NET_SLOTS_DEF];
    bit                 rank_known [NET_SLOTS_DEF];
    logic [CNT_FW-1:0]  walk_count;

    // Results still owed by the block, oldest first.
    fcc_out_t pending_results [$];

    int errors;
    int items_sent;
    int checks_sent;
    int results_seen;
    int conflicts_seen;
    int quiet_cycles;
    int stall_left;
    bit calm;     // phase with no idling on either side
    int win_lo;   // corner of the crowded grid window of the current phase

    // Ranks actually walked: values above the table size act as the size.
    function automatic int walk_limit();
        return (int'(walk_count) > NET_SLOTS_DEF) ? NET_SLOTS_DEF : int'(walk_count);
    endfunction

    function automatic bit spacing_violated(
        input logic [POS_FW-1:0] ax,
        input logic [POS_FW-1:0] ay,
        input logic [POS_FW-1:0] bx,
        input logic [POS_FW-1:0] by
    );
        int ddx;
        int ddy;
        ddx = int'(ax) - int'(bx);
        ddy = int'(ay) - int'(by);
        if (ddx < 0)
            ddx = -ddx;
        if (ddy < 0)
            ddy = -ddy;
        return (ddx < MIN_SPACING) && (ddy < MIN_SPACING);
    endfunction

    // Walk the ranks in order, stop at the checked net, report the first
    // rank whose net sits too close at t or, past the first step, at t - 1.
    function automatic fcc_out_t first_conflict(input fcc_in_t w);
        fcc_out_t r;
        int       other;
        int       t;
        r = '0;
        t = int'(w.time_step);
        for (int i = 0; i < walk_limit(); i++)
        begin
            if (rank_net[i] == w.net)
                break;
            other = int'(rank_net[i]);
            if (spacing_violated(w.pos_x, w.pos_y, path_x[other][t], path_y[other][t]) ||
                (t > 0 && spacing_violated(w.pos_x, w.pos_y,
                                           path_x[other][t-1], path_y[other][t-1])))
            begin
                r.conflict      = 1'b1;
                r.conflict_rank = RANK_FW'(i);
                break;
            end
        end
        return r;
    endfunction

    // Fold one accepted word into the local tables, or queue its result.
    task automatic absorb_word(input fcc_in_t w);
        case (w.func)
            FUNC_PATH:
            begin
                path_x[w.net][w.time_step]     = w.pos_x;
                path_y[w.net][w.time_step]     = w.pos_y;
                path_known[w.net][w.time_step] = 1'b1;
            end
            FUNC_ORDER:
            begin
                rank_net[w.slot]   = w.net;
                rank_known[w.slot] = 1'b1;
            end
            FUNC_CHECK:
            begin
                pending_results = {pending_results, first_conflict(w)};
                checks_sent++;
            end
            default: ;
        endcase
    endtask

    // Mostly back to back, some short gaps, a few long ones.
    function automatic int pick_gap();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Half of the coordinates land in a 6-wide window, so conflicts are common.
    function automatic logic [POS_FW-1:0] pick_pos();
        if ($urandom_range(0, 1) == 1)
            return POS_FW'(win_lo + $urandom_range(0, 5));
        return POS_FW'($urandom_range(0, 63));
    endfunction

    // Cluster time steps at both ends so the tables fill quickly and the
    // top bit of time_step is exercised.
    function automatic int pick_time();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80)
            return $urandom_range(0, 5);
        if (r < 95)
            return $urandom_range(122, 127);
        return $urandom_range(0, 127);
    endfunction

    // Checked net: often one that sits in the walked ranks, so walks stop early.
    function automatic int pick_check_net();
        int s;
        if (walk_limit() > 0 && $urandom_range(0, 1) == 1)
        begin
            s = $urandom_range(0, walk_limit() - 1);
            if (rank_known[s])
                return int'(rank_net[s]);
        end
        return $urandom_range(0, 63);
    endfunction

    // Word with every field random; callers overwrite the fields that matter.
    function automatic fcc_in_t noise_word(input logic [FUNC_W-1:0] f);
        fcc_in_t w;
        w.func      = f;
        w.net       = NET_FW'($urandom);
        w.slot      = SLOT_FW'($urandom);
        w.time_step = TIME_FW'($urandom);
        w.pos_x     = POS_FW'($urandom);
        w.pos_y     = POS_FW'($urandom);
        return w;
    endfunction

    // ------------------------------------------------------------------
    // Request side. Called and returns at a falling edge. valid stays high
    // across back-to-back words and is dropped only ahead of a gap or by wait_drained.
    // ------------------------------------------------------------------
    task automatic send_word(input fcc_in_t w);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            req_if.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_if.payload <= w;
        req_if.valid   <= 1'b1;
        @(posedge clk);
        while (!req_if.ready)
            @(posedge clk);
        absorb_word(w);
        if (w.func != FUNC_NOP)
            items_sent++;
        @(negedge clk);
    endtask

    task automatic write_path(input int net, input int t,
                              input logic [POS_FW-1:0] x, input logic [POS_FW-1:0] y);
        fcc_in_t w;
        w           = noise_word(FUNC_PATH);
        w.net       = NET_FW'(net);
        w.time_step = TIME_FW'(t);
        w.pos_x     = x;
        w.pos_y     = y;
        send_word(w);
    endtask

    task automatic write_order(input int slot, input int net);
        fcc_in_t w;
        w      = noise_word(FUNC_ORDER);
        w.slot = SLOT_FW'(slot);
        w.net  = NET_FW'(net);
        send_word(w);
    endtask

    // Fill in whatever the walk would read that is still unwritten, then
    // send the check itself.
    task automatic send_check(input int net, input int t,
                              input logic [POS_FW-1:0] x, input logic [POS_FW-1:0] y);
        fcc_in_t w;
        int      other;
        for (int i = 0; i < walk_limit(); i++)
        begin
            if (!rank_known[i])
                write_order(i, $urandom_range(0, 63));
            if (rank_net[i] == NET_FW'(net))
                break;
            other = int'(rank_net[i]);
            if (!path_known[other][t])
                write_path(other, t, pick_pos(), pick_pos());
            if (t > 0 && !path_known[other][t-1])
                write_path(other, t - 1, pick_pos(), pick_pos());
        end
        w           = noise_word(FUNC_CHECK);
        w.net       = NET_FW'(net);
        w.time_step = TIME_FW'(t);
        w.pos_x     = x;
        w.pos_y     = y;
        send_word(w);
    endtask

    // Drop valid, wait for every owed result, then let trailing writes land.
    task automatic wait_drained();
        req_if.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // ------------------------------------------------------------------
    // APB register access, setup then access phase.
    // ------------------------------------------------------------------
    task automatic reg_read_check(input logic [CNT_FW-1:0] want);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= REG_NET_COUNT;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (prdata[CNT_FW-1:0] !== want)
        begin
            $display("%0t ns: net_count readback mismatch, expected %0d got %0d",
                     $time, want, prdata[CNT_FW-1:0]);
            errors++;
        end
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
    endtask

    task automatic set_walk_count(input int value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= REG_NET_COUNT;
        pwdata  <= 32'(value);
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        walk_count = CNT_FW'(value);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
        reg_read_check(walk_count);
    endtask

    // ------------------------------------------------------------------
    // Response side: random stalls on ready, checker on every handshake.
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            rsp_if.ready <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            rsp_if.ready <= 1'b0;
            stall_left--;
        end
        else
        begin
            rsp_if.ready <= 1'b1;
            stall_left = pick_gap();
        end
    end

    always @(posedge clk)
    begin : rsp_check
        fcc_out_t got;
        fcc_out_t want;
        if (rst_n && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1)
        begin
            got = rsp_if.payload;
            if (pending_results.size() == 0)
            begin
                $display("%0t ns: result word with none expected, got conflict %0b rank %0d",
                         $time, got.conflict, got.conflict_rank);
                errors++;
            end
            else
            begin
                want = pending_results.pop_front();
                results_seen++;
                if (want.conflict)
                    conflicts_seen++;
                if (got.conflict !== want.conflict)
                begin
                    $display("%0t ns: conflict mismatch, expected %0b got %0b",
                             $time, want.conflict, got.conflict);
                    errors++;
                end
                if (got.conflict_rank !== want.conflict_rank)
                begin
                    $display("%0t ns: conflict_rank mismatch, expected %0d got %0d",
                             $time, want.conflict_rank, got.conflict_rank);
                    errors++;
                end
            end
        end
    end

    // Watchdog: any handshake on either channel or the register port
    // counts as progress.
    always @(posedge clk)
    begin
        if (!rst_n || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
            (psel && penable && pready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= IDLE_LIMIT)
        begin
            $display("%0t ns: no handshake for %0d cycles, %0d results outstanding",
                     $time, IDLE_LIMIT, pending_results.size());
            $display("tb: FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Out of reset net_count is 0: checks walk nothing and report no
    // conflict, and an unused func value is swallowed.
    task automatic test_reset_state();
        reg_read_check('0);
        send_check($urandom_range(0, 63), 0, pick_pos(), pick_pos());
        send_word(noise_word(FUNC_NOP));
        send_check($urandom_range(0, 63), 127, pick_pos(), pick_pos());
    endtask

    // Hand-placed tables: same-step and previous-step hits, no previous
    // step at t = 0, walks that stop at the checked net, grid corners and
    // the last time steps.
    task automatic test_spacing_directed();
        wait_drained();
        set_walk_count(NET_SLOTS_DEF);
        write_order(0, 5);
        write_order(1, 9);
        write_order(2, 63);
        write_path(5, 0, 6'd0, 6'd0);
        write_path(9, 0, 6'd63, 6'd63);
        write_path(5, 1, 6'd10, 6'd10);
        write_path(9, 1, 6'd20, 6'd20);
        write_path(5, 126, 6'd0, 6'd63);
        write_path(5, 127, 6'd63, 6'd0);
        write_path(9, 126, 6'd40, 6'd40);
        write_path(9, 127, 6'd41, 6'd41);
        send_check(63, 0, 6'd1, 6'd1);      // diagonal neighbor at rank 0
        send_check(63, 0, 6'd2, 6'd1);      // x distance exactly 2: clear
        send_check(5, 0, 6'd0, 6'd0);       // checked net holds rank 0: no walk
        send_check(63, 1, 6'd62, 6'd62);    // only the previous step collides
        send_check(63, 1, 6'd21, 6'd21);    // current step collides at rank 1
        send_check(63, 0, 6'd21, 6'd21);    // first step: no look back
        send_check(63, 127, 6'd62, 6'd1);   // last step, current position
        send_check(63, 127, 6'd1, 6'd62);   // last step, previous position
        send_check(63, 127, 6'd42, 6'd42);  // rank 1 hit after rank 0 clears
        send_check(9, 127, 6'd41, 6'd41);   // walk stops before rank 1
        send_word(noise_word(FUNC_NOP));
    endtask

    // Random table traffic and checks, one net_count setting per phase.
    task automatic test_random_traffic();
        int setting;
        int start;
        int r;
        int lim;
        for (int k = 0; k < PHASES; k++)
        begin
            case (k)
                0:       setting = 1;
                1:       setting = 127;
                2:       setting = 0;
                3:       setting = 64;
                4:       setting = 2;
                5:       setting = 65;
                6:       setting = 63;
                default: setting = $urandom_range(3, 62);
            endcase
            wait_drained();
            set_walk_count(setting);
            win_lo = $urandom_range(0, 58);
            calm   = ($urandom_range(0, 3) == 0);
            start  = items_sent;
            while (items_sent - start < PHASE_ITEMS)
            begin
                r   = $urandom_range(0, 99);
                lim = walk_limit();
                if (r < 30)
                begin
                    write_path($urandom_range(0, 63), pick_time(), pick_pos(), pick_pos());
                end
                else if (r < 42)
                begin
                    if (lim > 0 && $urandom_range(0, 4) != 0)
                        write_order($urandom_range(0, lim - 1), $urandom_range(0, 63));
                    else
                        write_order($urandom_range(0, 63), $urandom_range(0, 63));
                end
                else if (r < 95)
                begin
                    send_check(pick_check_net(), pick_time(), pick_pos(), pick_pos());
                end
                else
                begin
                    send_word(noise_word(FUNC_NOP));
                end
            end
        end
        calm = 1'b0;
    endtask

    initial
    begin
        rst_n          = 1'b0;
        req_if.valid   = 1'b0;
        req_if.payload = '0;
        rsp_if.ready   = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        walk_count     = '0;
        errors         = 0;
        items_sent     = 0;
        checks_sent    = 0;
        results_seen   = 0;
        conflicts_seen = 0;
        quiet_cycles   = 0;
        stall_left     = 0;
        calm           = 1'b0;
        win_lo         = 20;

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_reset_state();
        test_spacing_directed();
        test_random_traffic();

        wait_drained();
        repeat (TAIL_CYCLES) @(negedge clk);

        $display("summary: %0d table and check words, %0d checks, %0d results, %0d conflicts",
                 items_sent, checks_sent, results_seen, conflicts_seen);
        $display("summary: net_count swept over 0, 1, 2, 63, 64, 65, 127; %0d errors", errors);
        if (errors == 0 && pending_results.size() == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule
